[rtl/vss_pkg.sv]
`timescale 1ns / 1ps

package vss_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_DUP   = 3'd3,
        CMD_SWAP  = 3'd4,
        CMD_CLEAR = 3'd5,
        CMD_SORT  = 3'd6,
        CMD_DUMP  = 3'd7
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_FEW   = 2'd3
    } t_status;

endpackage

[rtl/vss_ram.sv]
`timescale 1ns / 1ps

// Entry store: one write port, one read port, registered read data.
module vss_ram
    import vss_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/value_stack_with_sort_core.sv]
`timescale 1ns / 1ps

// Channel      | Handshake                 | Payload
// -------------+---------------------------+------------------------------------------
// command in   | start (accepted, !busy)   | i_command, i_push_value
// result out   | o_valid, one cycle each   | o_value, o_status, o_entry_count, o_last
//
// Steps: push and clear answer from the execute state; pop, peek and
// duplicate after one RAM read; swap after reading top and second and
// writing both back. Dump shows the bottom entry first, then one per cycle
// up to the top. Sort is insertion sort over the single-port-read entry RAM
// with one signed comparator; its worst case is a reversed stack.
// Reset: synchronous, active low; clears the sequencer and the fill count.
// The entry RAM is not cleared; only entries below the fill count are read.
// Stalls: the receiver cannot stall; busy is high from acceptance until the
// final result of the transaction is registered on the outputs.
module value_stack_with_sort_core
    import vss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_value,
    output logic [STAT_W-1:0]        o_status,
    output logic [CNT_W-1:0]         o_entry_count,
    output logic                     o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states, one-hot
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_EXEC  = 11'b000_0000_0010,
        S_RDW   = 11'b000_0000_0100,  // pop / peek / dup read data back
        S_SW2   = 11'b000_0000_1000,  // swap: hold top, read second
        S_SW3   = 11'b000_0001_0000,  // swap: second -> top slot
        S_SW4   = 11'b000_0010_0000,  // swap: top -> second slot
        S_SOKEY = 11'b000_0100_0000,  // sort: fetch next key
        S_SOKW  = 11'b000_1000_0000,  // sort: latch key
        S_SOCMP = 11'b001_0000_0000,  // sort: compare and shift
        S_SOPUT = 11'b010_0000_0000,  // sort: key lands at slot zero
        S_DUMP  = 11'b100_0000_0000
    } t_state;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [DATA_W-1:0]   r_pv, n_pv;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [DATA_W-1:0]   r_key, n_key;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_value;
    t_status             r_out_status;
    logic [CW-1:0]       r_out_cnt;
    logic                r_out_last;

    // result emitted this cycle
    logic                e_valid;
    logic [DATA_W-1:0]   e_value;
    t_status             e_status;
    logic                e_last;

    // RAM access
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [DATA_W-1:0]   ram_wdata, ram_rdata;

    logic                cnt_full, cnt_empty, key_less;
    logic [CW-1:0]       cnt_m1, cnt_m2, j_m1, j_m2;

    vss_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cnt_full  = (r_cnt == CW'(DEPTH));
    assign cnt_empty = (r_cnt == '0);
    assign cnt_m1    = r_cnt - CW'(1);
    assign cnt_m2    = r_cnt - CW'(2);
    assign j_m1      = r_j - CW'(1);
    assign j_m2      = r_j - CW'(2);

    // The one shared compare: stored entry above the key moves up a slot.
    assign key_less  = ($signed(ram_rdata) > $signed(r_key));

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_pv      = r_pv;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_j       = r_j;
        n_key     = r_key;
        e_valid   = 1'b0;
        e_value   = '0;
        e_status  = ST_OK;
        e_last    = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_key;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_command);
                    n_pv    = i_push_value;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_cmd)
                    CMD_PUSH: begin
                        e_valid = 1'b1;
                        n_state = S_IDLE;
                        if (cnt_full) begin
                            e_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_cnt[AW-1:0];
                            ram_wdata = r_pv;
                            n_cnt     = r_cnt + CW'(1);
                        end
                    end
                    CMD_POP, CMD_PEEK: begin
                        if (cnt_empty) begin
                            e_valid  = 1'b1;
                            e_status = ST_EMPTY;
                            n_state  = S_IDLE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = cnt_m1[AW-1:0];
                            n_state   = S_RDW;
                        end
                    end
                    CMD_DUP: begin
                        if (cnt_empty) begin
                            e_valid  = 1'b1;
                            e_status = ST_EMPTY;
                            n_state  = S_IDLE;
                        end else if (cnt_full) begin
                            e_valid  = 1'b1;
                            e_status = ST_FULL;
                            n_state  = S_IDLE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = cnt_m1[AW-1:0];
                            n_state   = S_RDW;
                        end
                    end
                    CMD_SWAP: begin
                        if (r_cnt < CW'(2)) begin
                            e_valid  = 1'b1;
                            e_status = ST_FEW;
                            n_state  = S_IDLE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = cnt_m1[AW-1:0];
                            n_state   = S_SW2;
                        end
                    end
                    CMD_CLEAR: begin
                        n_cnt   = '0;
                        e_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_SORT: begin
                        n_i     = CW'(1);
                        n_state = S_SOKEY;
                    end
                    CMD_DUMP: begin
                        if (cnt_empty) begin
                            e_valid  = 1'b1;
                            e_status = ST_EMPTY;
                            n_state  = S_IDLE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_i       = CW'(1);
                            n_state   = S_DUMP;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            S_RDW: begin
                e_valid = 1'b1;
                n_state = S_IDLE;
                priority if (r_cmd == CMD_POP) begin
                    e_value = ram_rdata;
                    n_cnt   = cnt_m1;
                end else if (r_cmd == CMD_PEEK) begin
                    e_value = ram_rdata;
                end else begin
                    // duplicate
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt[AW-1:0];
                    ram_wdata = ram_rdata;
                    n_cnt     = r_cnt + CW'(1);
                end
            end

            S_SW2: begin
                n_key     = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = cnt_m2[AW-1:0];
                n_state   = S_SW3;
            end

            S_SW3: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_m1[AW-1:0];
                ram_wdata = ram_rdata;
                n_state   = S_SW4;
            end

            S_SW4: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_m2[AW-1:0];
                ram_wdata = r_key;
                e_valid   = 1'b1;
                n_state   = S_IDLE;
            end

            S_SOKEY: begin
                if (r_i >= r_cnt) begin
                    e_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_i[AW-1:0];
                    n_j       = r_i;
                    n_state   = S_SOKW;
                end
            end

            S_SOKW: begin
                n_key     = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = j_m1[AW-1:0];
                n_state   = S_SOCMP;
            end

            S_SOCMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                if (key_less) begin
                    // shift entry up, look one slot lower
                    ram_wdata = ram_rdata;
                    n_j       = j_m1;
                    if (j_m1 == '0) begin
                        n_state = S_SOPUT;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = j_m2[AW-1:0];
                    end
                end else begin
                    ram_wdata = r_key;
                    n_i       = r_i + CW'(1);
                    n_state   = S_SOKEY;
                end
            end

            S_SOPUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = r_key;
                n_i       = r_i + CW'(1);
                n_state   = S_SOKEY;
            end

            S_DUMP: begin
                e_valid = 1'b1;
                e_value = ram_rdata;
                e_last  = (r_i == r_cnt);
                if (r_i == r_cnt) begin
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_i[AW-1:0];
                    n_i       = r_i + CW'(1);
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_pv  <= n_pv;
        r_i   <= n_i;
        r_j   <= n_j;
        r_key <= n_key;
        if (e_valid) begin
            r_out_value  <= e_value;
            r_out_status <= e_status;
            r_out_cnt    <= n_cnt;
            r_out_last   <= e_last;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_value       = r_out_value;
    assign o_status      = r_out_status;
    assign o_entry_count = CNT_W'(r_out_cnt);
    assign o_last        = r_out_last;

    // Fill count never passes the stack depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("fill count above depth");

    // An accepted command always occupies the sequencer next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but sequencer idle");

    // The final result of a transaction leaves the sequencer idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("final result while still busy");

    // More dump results are still coming while a non-final one is shown.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result with idle sequencer");

    // Sorting never changes the fill count.
    a_sort_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SOCMP) |=> $stable(r_cnt))
        else $error("fill count changed during sort");

endmodule

[tb/sv/value_stack_with_sort_core_test.sv]
`timescale 1ns / 1ps

module value_stack_with_sort_core_test;
    import vss_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int MAX_REPORTS = 30;

    // One result of a command transaction, in port order.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } t_stack_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         i_command;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_value;
    logic [STAT_W-1:0]        o_status;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     o_last;

    value_stack_with_sort_core #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_entry_count(o_entry_count),
        .o_last       (o_last)
    );

    // Shadow of the stack: entries below shadow_held are live.
    logic signed [DATA_W-1:0] shadow_mem [STACK_DEPTH];
    int                       shadow_held;

    // Results still owed by the block, oldest first.
    t_stack_result pending_results[$];
    t_stack_result observed_want;

    int mismatch_count;
    bit sender_idles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. The slowest legal transaction is a sort of a reversed full
    // stack; this covers far more than the run needs.
    initial begin
        #(50_000_000);
        $display("FAIL value_stack_with_sort_core");
        $finish;
    end

    // Apply one command to the shadow stack and queue the results it causes.
    task automatic predict_stack(input t_cmd cmd, input logic signed [DATA_W-1:0] word);
        t_stack_result            res;
        logic signed [DATA_W-1:0] key;
        int                       j;
        bit                       multi;
        res.value  = '0;
        res.status = ST_OK;
        res.last   = 1'b1;
        multi      = 1'b0;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_held < STACK_DEPTH) begin
                    shadow_mem[shadow_held] = word;
                    shadow_held++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            CMD_POP: begin
                if (shadow_held > 0) begin
                    shadow_held--;
                    res.value = shadow_mem[shadow_held];
                end else begin
                    res.status = ST_EMPTY;
                end
            end
            CMD_PEEK: begin
                if (shadow_held > 0)
                    res.value = shadow_mem[shadow_held-1];
                else
                    res.status = ST_EMPTY;
            end
            CMD_DUP: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else if (shadow_held >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_mem[shadow_held] = shadow_mem[shadow_held-1];
                    shadow_held++;
                end
            end
            CMD_SWAP: begin
                if (shadow_held > 1) begin
                    key                       = shadow_mem[shadow_held-1];
                    shadow_mem[shadow_held-1] = shadow_mem[shadow_held-2];
                    shadow_mem[shadow_held-2] = key;
                end else begin
                    res.status = ST_FEW;
                end
            end
            CMD_CLEAR: shadow_held = 0;
            CMD_SORT: begin
                // ascending, signed compare
                for (int i = 1; i < shadow_held; i++) begin
                    key = shadow_mem[i];
                    j   = i;
                    while (j > 0 && shadow_mem[j-1] > key) begin
                        shadow_mem[j] = shadow_mem[j-1];
                        j--;
                    end
                    shadow_mem[j] = key;
                end
            end
            default: begin
                // dump: bottom to top, last flag on the top entry
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    multi = 1'b1;
                    for (int i = 0; i < shadow_held; i++) begin
                        res.value = shadow_mem[i];
                        res.count = CNT_W'(shadow_held);
                        res.last  = (i == shadow_held - 1);
                        pending_results.push_back(res);
                    end
                end
            end
        endcase
        if (!multi) begin
            res.count = CNT_W'(shadow_held);
            pending_results.push_back(res);
        end
    endtask

    // Present one command and hold it until the block takes it. A fixed
    // expectation, where given, replaces the predicted one (always a single
    // result), while the shadow state still advances.
    task automatic send_command(input t_cmd cmd, input logic [DATA_W-1:0] word,
                                input bit fixed, input t_stack_result fixed_res);
        if (sender_idles && $urandom_range(99) < 15) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 50);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_push_value <= word;
        do @(posedge i_clk); while (busy);
        predict_stack(cmd, word);
        if (fixed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(fixed_res);
        end
    endtask

    // Drop start and hold off until every owed result has come back.
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] random_q16();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom;
        else if (pick < 85)
            // small whole and half values, many repeats to exercise equal keys
            return DATA_W'($signed($urandom_range(6)) - 3) <<< 15;
        else
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
    endfunction

    function automatic t_cmd random_command();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return CMD_PUSH;
        if (pick < 45) return CMD_POP;
        if (pick < 53) return CMD_PEEK;
        if (pick < 63) return CMD_DUP;
        if (pick < 73) return CMD_SWAP;
        if (pick < 76) return CMD_CLEAR;
        if (pick < 86) return CMD_SORT;
        return CMD_DUMP;
    endfunction

    function automatic t_stack_result status_only(input logic [DATA_W-1:0] value,
                                                  input t_status status, input int count);
        t_stack_result r;
        r.value  = value;
        r.status = status;
        r.count  = CNT_W'(count);
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endtask

    // Result checker: every strobe is matched to the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual value %h status %0d",
                             $time, o_value, o_status);
            end else begin
                observed_want = pending_results.pop_front();
                if (o_value !== observed_want.value)
                    report_mismatch("value", observed_want.value, o_value);
                if (o_status !== observed_want.status)
                    report_mismatch("status", DATA_W'(observed_want.status),
                                    DATA_W'(o_status));
                if (o_entry_count !== observed_want.count)
                    report_mismatch("entry_count", DATA_W'(observed_want.count),
                                    DATA_W'(o_entry_count));
                if (o_last !== observed_want.last)
                    report_mismatch("last", DATA_W'(observed_want.last), DATA_W'(o_last));
            end
        end
    end

    // Directed table: command, push word, fixed expectation flag, then the
    // fixed value / status / count where the answer is obvious.
    typedef struct {
        t_cmd              cmd;
        logic [DATA_W-1:0] word;
        bit                fixed;
        logic [DATA_W-1:0] want_value;
        t_status           want_status;
        int                want_count;
    } t_directed_row;

    t_directed_row directed_rows[$];

    task automatic add_row(input t_cmd cmd, input logic [DATA_W-1:0] word, input bit fixed,
                           input logic [DATA_W-1:0] want_value, input t_status want_status,
                           input int want_count);
        t_directed_row row;
        row.cmd         = cmd;
        row.word        = word;
        row.fixed       = fixed;
        row.want_value  = want_value;
        row.want_status = want_status;
        row.want_count  = want_count;
        directed_rows.push_back(row);
    endtask

    initial begin
        t_stack_result none;
        none           = '0;
        mismatch_count = 0;
        shadow_held    = 0;
        sender_idles   = 1'b1;
        start        <= 1'b0;
        i_command    <= CMD_PUSH;
        i_push_value <= '0;
        i_rst_n      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n      <= 1'b1;

        // every command but push and clear on an empty stack
        add_row(CMD_DUMP,  32'h0,         1'b1, 32'h0,         ST_EMPTY, 0);
        add_row(CMD_POP,   32'h0,         1'b1, 32'h0,         ST_EMPTY, 0);
        add_row(CMD_PEEK,  32'h0,         1'b1, 32'h0,         ST_EMPTY, 0);
        add_row(CMD_DUP,   32'h0,         1'b1, 32'h0,         ST_EMPTY, 0);
        add_row(CMD_SWAP,  32'h0,         1'b1, 32'h0,         ST_FEW,   0);
        add_row(CMD_SORT,  32'h0,         1'b1, 32'h0,         ST_OK,    0);
        // one entry: swap refused, sort no-op
        add_row(CMD_PUSH,  32'h7FFF_FFFF, 1'b1, 32'h0,         ST_OK,    1);
        add_row(CMD_SWAP,  32'h0,         1'b1, 32'h0,         ST_FEW,   1);
        add_row(CMD_SORT,  32'h0,         1'b1, 32'h0,         ST_OK,    1);
        add_row(CMD_PEEK,  32'h0,         1'b1, 32'h7FFF_FFFF, ST_OK,    1);
        // extremes, then shuffle them around
        add_row(CMD_PUSH,  32'h8000_0000, 1'b1, 32'h0,         ST_OK,    2);
        add_row(CMD_PUSH,  32'h0000_0000, 1'b1, 32'h0,         ST_OK,    3);
        add_row(CMD_PUSH,  32'hFFFF_FFFF, 1'b1, 32'h0,         ST_OK,    4);
        add_row(CMD_DUP,   32'h0,         1'b1, 32'h0,         ST_OK,    5);
        add_row(CMD_SWAP,  32'h0,         1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_PEEK,  32'h0,         1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_SORT,  32'h0,         1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_DUMP,  32'h0,         1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_POP,   32'h0,         1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_PUSH,  32'h0000_0001, 1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_CLEAR, 32'h0,         1'b1, 32'h0,         ST_OK,    0);
        add_row(CMD_DUMP,  32'h0,         1'b1, 32'h0,         ST_EMPTY, 0);
        add_row(CMD_PUSH,  32'h0001_0000, 1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_POP,   32'h0,         1'b0, 32'h0,         ST_OK,    0);
        add_row(CMD_POP,   32'h0,         1'b1, 32'h0,         ST_EMPTY, 0);

        foreach (directed_rows[k])
            send_command(directed_rows[k].cmd, directed_rows[k].word, directed_rows[k].fixed,
                         status_only(directed_rows[k].want_value, directed_rows[k].want_status,
                                     directed_rows[k].want_count));

        // sender backs off until the block has answered everything
        wait_all_results();

        // Fill phase: mostly pushes with random content until the stack is full.
        while (shadow_held < STACK_DEPTH) begin
            if ($urandom_range(99) < 88)
                send_command(CMD_PUSH, random_q16(), 1'b0, none);
            else
                send_command(t_cmd'($urandom_range(CMD_POP, CMD_SWAP)), random_q16(), 1'b0, none);
        end

        // full-stack corner: push and duplicate refused, then a 64-entry sort and dump
        send_command(CMD_PUSH, random_q16(), 1'b1, status_only('0, ST_FULL, STACK_DEPTH));
        send_command(CMD_DUP,  random_q16(), 1'b1, status_only('0, ST_FULL, STACK_DEPTH));
        send_command(CMD_SORT, random_q16(), 1'b0, none);
        send_command(CMD_DUMP, random_q16(), 1'b0, none);
        send_command(CMD_SWAP, random_q16(), 1'b0, none);
        send_command(CMD_POP,  random_q16(), 1'b0, none);
        send_command(CMD_DUP,  random_q16(), 1'b0, none);
        send_command(CMD_DUP,  random_q16(), 1'b1, status_only('0, ST_FULL, STACK_DEPTH));
        send_command(CMD_DUMP, random_q16(), 1'b0, none);

        // Mixed traffic; a stretch in the middle runs back-to-back with no idles.
        for (int n = 0; n < 110; n++) begin
            sender_idles = !(n >= 40 && n < 80);
            send_command(random_command(), random_q16(), 1'b0, none);
        end

        wait_all_results();
        // catch any stray strobes after the last owed result
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS value_stack_with_sort_core");
        else
            $display("FAIL value_stack_with_sort_core");
        $finish;
    end

endmodule
